// ===== hdl/pgq_pkg.sv =====
// Package for the plane geometry query unit: field widths, codes, payload
// structs and the fixed-point helper functions. No dependencies.
package pgq_pkg;

  localparam int COORD_W    = 32;
  localparam int NORM_W     = 18;
  localparam int THR_W      = 17;
  localparam int FRAC       = 16;
  localparam int DVD_W      = 64;
  localparam int DVS_W      = 48;
  localparam int DIV_STAGES = DVD_W;

  typedef enum logic [1:0] {
    CMD_RAY    = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_PLANES = 2'd2
  } cmd_e;

  localparam logic [1:0] SIDE_BACK  = 2'd0;
  localparam logic [1:0] SIDE_ON    = 2'd1;
  localparam logic [1:0] SIDE_FRONT = 2'd2;

  localparam logic [2:0] CFG_NORMAL_X  = 3'd0;
  localparam logic [2:0] CFG_NORMAL_Y  = 3'd1;
  localparam logic [2:0] CFG_NORMAL_Z  = 3'd2;
  localparam logic [2:0] CFG_OFFSET    = 3'd3;
  localparam logic [2:0] CFG_THRESHOLD = 3'd4;

  typedef struct packed {
    logic [2:0][NORM_W-1:0] n;
    logic signed [COORD_W-1:0] d;
    logic [THR_W-1:0] thr;
  } pgq_cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0][COORD_W-1:0] a;
    logic [2:0][COORD_W-1:0] b;
    logic [COORD_W-1:0] e;
  } pgq_item_t;

  // Results that bypass the divider
  typedef struct packed {
    logic [1:0] cmd;
    logic ok;
    logic [COORD_W-1:0] scalar;
    logic [1:0] side;
    logic [2:0][COORD_W-1:0] out_a;
    logic [2:0][COORD_W-1:0] out_b;
  } pgq_pay_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
    logic neg;
  } pgq_div_in_t;

  typedef struct packed {
    logic hit;
    logic [COORD_W-1:0] scalar;
    logic [1:0] side;
    logic [2:0][COORD_W-1:0] out_a;
    logic [2:0][COORD_W-1:0] out_b;
  } pgq_res_t;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  function automatic logic signed [49:0] mul_n(input logic signed [17:0] n,
                                               input logic signed [31:0] x);
    logic signed [49:0] p;
    p = n * x;
    return p;
  endfunction

  function automatic logic signed [63:0] mul_w(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    logic signed [63:0] p;
    p = x * y;
    return p;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > MAX32) return 32'sh7FFF_FFFF;
    if (x < MIN32) return 32'sh8000_0000;
    return $signed(x[31:0]);
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [48:0] x);
    if (x > 49'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (x < -49'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
    return $signed(x[47:0]);
  endfunction

  // Signed, saturated value from a magnitude and a sign
  function automatic logic [31:0] mag_to32(input logic [63:0] q, input logic neg);
    if (!neg) begin
      if (|q[63:31]) return 32'h7FFF_FFFF;
      return q[31:0];
    end
    if ((|q[63:32]) || (q[31] && (|q[30:0]))) return 32'h8000_0000;
    return 32'(-q[31:0]);
  endfunction

endpackage

// ===== hdl/pgq_front.sv =====
// Six-stage front end: dot and cross products, reflection, line direction and
// divider operands. Depends on pgq_pkg.
module pgq_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  pgq_pkg::pgq_item_t     item_i,
  input  pgq_pkg::pgq_cfg_t      cfg_i,
  output logic                   valid_o,
  output pgq_pkg::pgq_pay_t      pay_o,
  output pgq_pkg::pgq_div_in_t   div_o [3]
);

  logic signed [17:0] nrm [3];
  always_comb begin
    for (int i = 0; i < 3; i++) nrm[i] = $signed(cfg_i.n[i]);
  end

  logic [5:0] vld_q;

  // stage 1
  logic [1:0]         s1_cmd_q;
  logic signed [31:0] s1_a_q [3];
  logic signed [31:0] s1_e_q;
  logic signed [51:0] s1_dota_q, s1_dotb_q, s1_dota_d, s1_dotb_d;
  logic signed [50:0] s1_cr_q [3], s1_cr_d [3];

  always_comb begin
    int j, k;
    s1_dota_d = '0;
    s1_dotb_d = '0;
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      s1_dota_d = s1_dota_d + 52'(pgq_pkg::mul_n(nrm[i], $signed(item_i.a[i])));
      s1_dotb_d = s1_dotb_d + 52'(pgq_pkg::mul_n(nrm[i], $signed(item_i.b[i])));
      s1_cr_d[i] = 51'(pgq_pkg::mul_n(nrm[j], $signed(item_i.a[k])))
                 - 51'(pgq_pkg::mul_n(nrm[k], $signed(item_i.a[j])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cmd_q  <= item_i.cmd;
      s1_e_q    <= $signed(item_i.e);
      s1_dota_q <= s1_dota_d;
      s1_dotb_q <= s1_dotb_d;
      for (int i = 0; i < 3; i++) begin
        s1_a_q[i]  <= $signed(item_i.a[i]);
        s1_cr_q[i] <= s1_cr_d[i];
      end
    end
  end

  // stage 2
  logic [1:0]         s2_cmd_q;
  logic signed [31:0] s2_a_q [3];
  logic signed [31:0] s2_e_q;
  logic signed [35:0] s2_den0_q;
  logic signed [36:0] s2_dist_q;
  logic signed [31:0] s2_v_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_e_q    <= s1_e_q;
      s2_den0_q <= $signed(s1_dotb_q[51:16]);
      s2_dist_q <= 37'($signed(s1_dota_q[51:16])) + 37'(cfg_i.d);
      for (int i = 0; i < 3; i++) begin
        s2_a_q[i] <= s1_a_q[i];
        s2_v_q[i] <= pgq_pkg::sat32(64'($signed(s1_cr_q[i][50:16])));
      end
    end
  end

  // stage 3
  logic [1:0]         s3_cmd_q;
  logic signed [31:0] s3_a_q [3];
  logic signed [31:0] s3_e_q;
  logic signed [36:0] s3_dist_q;
  logic signed [31:0] s3_v_q [3];
  logic               s3_ok0_q, s3_neg0_q;
  logic [35:0]        s3_mag0_q, s3_mag0_d;
  logic [63:0]        s3_dvd0_q;
  logic [36:0]        s3_mdist_d;
  logic signed [54:0] s3_rp_q [3];
  logic signed [63:0] s3_sq_q [3], s3_pa_q [3], s3_pb_q [3];
  logic signed [49:0] s3_qa_q [3], s3_qb_q [3];

  always_comb begin
    s3_mag0_d  = s2_den0_q[35] ? 36'(-s2_den0_q) : 36'(s2_den0_q);
    s3_mdist_d = s2_dist_q[36] ? 37'(-s2_dist_q) : 37'(s2_dist_q);
  end

  always_ff @(posedge clk_i) begin
    int j, k;
    if (en_i) begin
      s3_cmd_q  <= s2_cmd_q;
      s3_e_q    <= s2_e_q;
      s3_dist_q <= s2_dist_q;
      s3_mag0_q <= s3_mag0_d;
      s3_ok0_q  <= (s2_den0_q != '0) && (s3_mag0_d >= 36'(cfg_i.thr));
      // t is negative when numerator and denominator share a sign
      s3_neg0_q <= ~(s2_dist_q[36] ^ s2_den0_q[35]);
      s3_dvd0_q <= {11'b0, s3_mdist_d, 16'b0};
      for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        s3_a_q[i]  <= s2_a_q[i];
        s3_v_q[i]  <= s2_v_q[i];
        s3_rp_q[i] <= 55'(nrm[i]) * 55'(s2_dist_q);
        s3_sq_q[i] <= pgq_pkg::mul_w(s2_v_q[i], s2_v_q[i]);
        s3_pa_q[i] <= pgq_pkg::mul_w(s2_v_q[j], s2_a_q[k]);
        s3_pb_q[i] <= pgq_pkg::mul_w(s2_v_q[k], s2_a_q[j]);
        s3_qa_q[i] <= pgq_pkg::mul_n(nrm[j], s2_v_q[k]);
        s3_qb_q[i] <= pgq_pkg::mul_n(nrm[k], s2_v_q[j]);
      end
    end
  end

  // stage 4
  logic [1:0]         s4_cmd_q;
  logic signed [31:0] s4_e_q;
  logic signed [31:0] s4_v_q [3];
  logic               s4_ok0_q, s4_neg0_q;
  logic [35:0]        s4_mag0_q;
  logic [63:0]        s4_dvd0_q;
  logic [31:0]        s4_scal_q;
  logic [1:0]         s4_side_q;
  logic [31:0]        s4_refl_q [3];
  logic [47:0]        s4_den2_q;
  logic signed [31:0] s4_w_q [3], s4_u_q [3];
  logic [63:0]        s4_sum_d;
  logic signed [50:0] s4_qd_d [3];

  always_comb begin
    s4_sum_d = $unsigned(s3_sq_q[0]) + $unsigned(s3_sq_q[1]) + $unsigned(s3_sq_q[2]);
    for (int i = 0; i < 3; i++) s4_qd_d[i] = 51'(s3_qa_q[i]) - 51'(s3_qb_q[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_cmd_q  <= s3_cmd_q;
      s4_e_q    <= s3_e_q;
      s4_ok0_q  <= s3_ok0_q;
      s4_neg0_q <= s3_neg0_q;
      s4_mag0_q <= s3_mag0_q;
      s4_dvd0_q <= s3_dvd0_q;
      s4_scal_q <= pgq_pkg::sat32(64'(s3_dist_q));
      s4_den2_q <= s4_sum_d[63:16];
      if (s3_dist_q < 0) s4_side_q <= pgq_pkg::SIDE_BACK;
      else if (s3_dist_q > 0) s4_side_q <= pgq_pkg::SIDE_FRONT;
      else s4_side_q <= pgq_pkg::SIDE_ON;
      for (int i = 0; i < 3; i++) begin
        s4_v_q[i]    <= s3_v_q[i];
        s4_refl_q[i] <= pgq_pkg::sat32(64'(41'(s3_a_q[i])
                                     - 41'($signed(s3_rp_q[i][54:15]))));
        s4_w_q[i]    <= pgq_pkg::sat32(64'(49'($signed(s3_pa_q[i][63:16]))
                                     - 49'($signed(s3_pb_q[i][63:16]))));
        s4_u_q[i]    <= pgq_pkg::sat32(64'($signed(s4_qd_d[i][50:16])));
      end
    end
  end

  // stage 5
  logic [1:0]         s5_cmd_q;
  logic signed [31:0] s5_v_q [3];
  logic               s5_ok0_q, s5_neg0_q, s5_ok2_q;
  logic [35:0]        s5_mag0_q;
  logic [63:0]        s5_dvd0_q;
  logic [31:0]        s5_scal_q;
  logic [1:0]         s5_side_q;
  logic [31:0]        s5_refl_q [3];
  logic [47:0]        s5_den2_q;
  logic signed [63:0] s5_wd_q [3], s5_ue_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_cmd_q  <= s4_cmd_q;
      s5_ok0_q  <= s4_ok0_q;
      s5_neg0_q <= s4_neg0_q;
      s5_mag0_q <= s4_mag0_q;
      s5_dvd0_q <= s4_dvd0_q;
      s5_scal_q <= s4_scal_q;
      s5_side_q <= s4_side_q;
      s5_den2_q <= s4_den2_q;
      s5_ok2_q  <= s4_den2_q > 48'(cfg_i.thr);
      for (int i = 0; i < 3; i++) begin
        s5_v_q[i]    <= s4_v_q[i];
        s5_refl_q[i] <= s4_refl_q[i];
        s5_wd_q[i]   <= pgq_pkg::mul_w(s4_w_q[i], cfg_i.d);
        s5_ue_q[i]   <= pgq_pkg::mul_w(s4_u_q[i], s4_e_q);
      end
    end
  end

  // stage 6: line point numerators, or the ray operands, become divider operands
  logic signed [47:0]   s6_num_d [3];
  logic [47:0]          s6_mag_d [3];
  pgq_pkg::pgq_div_in_t s6_div_d [3], s6_div_q [3];
  pgq_pkg::pgq_pay_t    s6_pay_d, s6_pay_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_num_d[i] = pgq_pkg::clamp48(49'($signed(s5_wd_q[i][63:16]))
                                   + 49'($signed(s5_ue_q[i][63:16])));
      s6_mag_d[i] = s6_num_d[i][47] ? 48'(-s6_num_d[i]) : 48'(s6_num_d[i]);
      s6_div_d[i].dvd = {s6_mag_d[i], 16'b0};
      s6_div_d[i].dvs = s5_den2_q;
      s6_div_d[i].neg = s6_num_d[i][47];
    end
    if (s5_cmd_q == pgq_pkg::CMD_RAY) begin
      s6_div_d[0].dvd = s5_dvd0_q;
      s6_div_d[0].dvs = 48'(s5_mag0_q);
      s6_div_d[0].neg = s5_neg0_q;
    end
    s6_pay_d.cmd    = s5_cmd_q;
    s6_pay_d.ok     = (s5_cmd_q == pgq_pkg::CMD_RAY) ? s5_ok0_q : s5_ok2_q;
    s6_pay_d.scalar = s5_scal_q;
    s6_pay_d.side   = s5_side_q;
    for (int i = 0; i < 3; i++) begin
      s6_pay_d.out_a[i] = s5_refl_q[i];
      s6_pay_d.out_b[i] = s5_v_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_pay_q <= s6_pay_d;
      for (int i = 0; i < 3; i++) s6_div_q[i] <= s6_div_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o = vld_q[5];
  assign pay_o   = s6_pay_q;
  always_comb begin
    for (int i = 0; i < 3; i++) div_o[i] = s6_div_q[i];
  end

endmodule

// ===== hdl/pgq_div_lane.sv =====
// One lane of the pipelined restoring divider, one quotient bit per stage.
// Depends on pgq_pkg.
module pgq_div_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  pgq_pkg::pgq_div_in_t        lane_i,
  output logic [pgq_pkg::DVD_W-1:0]   quo_o,
  output logic                        neg_o
);

  localparam int N  = pgq_pkg::DIV_STAGES;
  localparam int DW = pgq_pkg::DVD_W;
  localparam int RW = pgq_pkg::DVS_W;

  logic [DW-1:0] dq_q  [N];
  logic [RW-1:0] rem_q [N];
  logic [RW-1:0] dvs_q [N];
  logic          neg_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [DW-1:0] dq_in;
    logic [RW-1:0] rem_in, dvs_in;
    logic          neg_in, ge;
    logic [RW:0]   trial, diff;

    if (k == 0) begin : g_first
      assign dq_in  = lane_i.dvd;
      assign rem_in = '0;
      assign dvs_in = lane_i.dvs;
      assign neg_in = lane_i.neg;
    end else begin : g_next
      assign dq_in  = dq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    // shift in the next dividend bit, subtract where it fits
    assign trial = {rem_in, dq_in[DW-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign ge    = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dq_q[k]  <= {dq_in[DW-2:0], ge};
        rem_q[k] <= ge ? diff[RW-1:0] : trial[RW-1:0];
        dvs_q[k] <= dvs_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  assign quo_o = dq_q[N-1];
  assign neg_o = neg_q[N-1];

endmodule

// ===== hdl/pgq_back.sv =====
// Result selection by command, sign and saturation of quotients, and the
// output register with its skid stage. Depends on pgq_pkg.
module pgq_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  pgq_pkg::pgq_pay_t                pay_i,
  input  logic [2:0][pgq_pkg::DVD_W-1:0]   quo_i,
  input  logic [2:0]                       neg_i,
  input  logic                             out_ready_i,
  output logic                             en_o,
  output logic                             out_valid_o,
  output pgq_pkg::pgq_res_t                res_o
);

  pgq_pkg::pgq_res_t res_d, out_q, skid_q;
  logic out_valid_q, skid_valid_q;

  always_comb begin
    res_d = '0;
    unique case (pay_i.cmd)
      pgq_pkg::CMD_RAY: begin
        if (pay_i.ok) begin
          res_d.scalar = pgq_pkg::mag_to32(quo_i[0], neg_i[0]);
          res_d.hit    = ~neg_i[0] && (quo_i[0] != '0);
        end
      end
      pgq_pkg::CMD_POINT: begin
        res_d.hit    = 1'b1;
        res_d.scalar = pay_i.scalar;
        res_d.side   = pay_i.side;
        res_d.out_a  = pay_i.out_a;
      end
      pgq_pkg::CMD_PLANES: begin
        if (pay_i.ok) begin
          res_d.hit   = 1'b1;
          res_d.out_b = pay_i.out_b;
          for (int i = 0; i < 3; i++) res_d.out_a[i] = pgq_pkg::mag_to32(quo_i[i], neg_i[i]);
        end
      end
      default: res_d = '0;
    endcase
  end

  // the pipe runs while the skid stage is empty
  assign en_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= valid_i;
    end else if (valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) out_q <= skid_q;
    end else if (!out_valid_q || out_ready_i) begin
      out_q <= res_d;
    end else if (valid_i) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ===== hdl/plane_geometry_query_unit_core.sv =====
// Top level of the plane geometry query unit: configuration registers, front
// end, three divider lanes with the matching payload delay line, back end.
// Depends on pgq_pkg, pgq_front, pgq_div_lane, pgq_back.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | command_i, vec_a_*, vec_b_*, other_offset_i
//   out     | out       | out_valid_o/out_ready_i | hit_o, scalar_value_o, side_o, out_a_*, out_b_*
//
// One transaction per cycle while the output is not stalled; each result passes
// through six front-end stages, 64 stages of the restoring divider (one quotient
// bit each) and one output register. cfg_ready_o is always high.
// Reset clears the valid bits and loads the default plane registers; no clearing pass.
// A stalled output fills one skid stage, then the whole pipe holds.
module plane_geometry_query_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [pgq_pkg::COORD_W-1:0] vec_a_x_i,
  input  logic [pgq_pkg::COORD_W-1:0] vec_a_y_i,
  input  logic [pgq_pkg::COORD_W-1:0] vec_a_z_i,
  input  logic [pgq_pkg::COORD_W-1:0] vec_b_x_i,
  input  logic [pgq_pkg::COORD_W-1:0] vec_b_y_i,
  input  logic [pgq_pkg::COORD_W-1:0] vec_b_z_i,
  input  logic [pgq_pkg::COORD_W-1:0] other_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [pgq_pkg::COORD_W-1:0] scalar_value_o,
  output logic [1:0]  side_o,
  output logic [pgq_pkg::COORD_W-1:0] out_a_x_o,
  output logic [pgq_pkg::COORD_W-1:0] out_a_y_o,
  output logic [pgq_pkg::COORD_W-1:0] out_a_z_o,
  output logic [pgq_pkg::COORD_W-1:0] out_b_x_o,
  output logic [pgq_pkg::COORD_W-1:0] out_b_y_o,
  output logic [pgq_pkg::COORD_W-1:0] out_b_z_o
);

  localparam int N = pgq_pkg::DIV_STAGES;

  pgq_pkg::pgq_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.n   <= {18'd65536, 18'd0, 18'd0};
      cfg_q.d   <= '0;
      cfg_q.thr <= 17'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pgq_pkg::CFG_NORMAL_X:  cfg_q.n[0] <= cfg_data_i[17:0];
        pgq_pkg::CFG_NORMAL_Y:  cfg_q.n[1] <= cfg_data_i[17:0];
        pgq_pkg::CFG_NORMAL_Z:  cfg_q.n[2] <= cfg_data_i[17:0];
        pgq_pkg::CFG_OFFSET:    cfg_q.d    <= $signed(cfg_data_i);
        pgq_pkg::CFG_THRESHOLD: cfg_q.thr  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  logic en;
  pgq_pkg::pgq_item_t item;

  assign in_ready_o = en;
  assign item.cmd   = command_i;
  assign item.a     = {vec_a_z_i, vec_a_y_i, vec_a_x_i};
  assign item.b     = {vec_b_z_i, vec_b_y_i, vec_b_x_i};
  assign item.e     = other_offset_i;

  logic                 fr_valid;
  pgq_pkg::pgq_pay_t    fr_pay;
  pgq_pkg::pgq_div_in_t fr_div [3];

  pgq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (item),
    .cfg_i   (cfg_q),
    .valid_o (fr_valid),
    .pay_o   (fr_pay),
    .div_o   (fr_div)
  );

  logic [2:0][pgq_pkg::DVD_W-1:0] quo;
  logic [2:0]                     neg;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    pgq_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (fr_div[i]),
      .quo_o  (quo[i]),
      .neg_o  (neg[i])
    );
  end

  // payload and valid travel alongside the divider stages
  logic [N-1:0]      dly_vld_q;
  pgq_pkg::pgq_pay_t dly_pay_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_vld_q <= '0;
    end else if (en) begin
      dly_vld_q <= {dly_vld_q[N-2:0], fr_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_pay_q[0] <= fr_pay;
      for (int k = 1; k < N; k++) dly_pay_q[k] <= dly_pay_q[k-1];
    end
  end

  pgq_pkg::pgq_res_t res;

  pgq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dly_vld_q[N-1]),
    .pay_i       (dly_pay_q[N-1]),
    .quo_i       (quo),
    .neg_i       (neg),
    .out_ready_i (out_ready_i),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign hit_o          = res.hit;
  assign scalar_value_o = res.scalar;
  assign side_o         = res.side;
  assign out_a_x_o      = res.out_a[0];
  assign out_a_y_o      = res.out_a[1];
  assign out_a_z_o      = res.out_a[2];
  assign out_b_x_o      = res.out_b[0];
  assign out_b_y_o      = res.out_b[1];
  assign out_b_z_o      = res.out_b[2];

endmodule

// ===== hdl/pgq_checker.sv =====
// Port-level checker for the plane geometry query unit, bound to the top level.
// Depends on plane_geometry_query_unit_core ports only.
module pgq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        hit_o,
  input logic [31:0] scalar_value_o,
  input logic [1:0]  side_o,
  input logic [31:0] out_a_x_o,
  input logic [31:0] out_b_x_o,
  input logic [31:0] out_b_y_o,
  input logic [31:0] out_b_z_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(scalar_value_o) && $stable(out_a_x_o)
                                    && $stable(hit_o) && $stable(side_o))
    else $error("output payload changed while stalled");

  // only a point query reports a side, and it always hits
  a_side_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (side_o != 2'd0) |-> hit_o && (side_o != 2'd3))
    else $error("side reported without hit");

  // a line direction is given only for intersecting planes
  a_dir_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_b_x_o != 32'd0) || (out_b_y_o != 32'd0) || (out_b_z_o != 32'd0))
    |-> hit_o && (side_o == 2'd0))
    else $error("line direction without plane hit");

endmodule

bind plane_geometry_query_unit_core pgq_checker u_pgq_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for plane_geometry_query_unit_core: ray, point and
// plane-plane queries against a predicted result queue. Depends on pgq_pkg and plane_geometry_query_unit_core.
import pgq_pkg::*;

localparam logic [1:0] CMD_NONE = 2'd3;

class plane_query_scoreboard;
  longint nrm[3];
  longint offs;
  longint unsigned thr;
  pgq_res_t results_due[$];
  int errors;

  function new();
    nrm[0] = 0; nrm[1] = 0; nrm[2] = 65536;
    offs = 0; thr = 1; errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      CFG_NORMAL_X:  nrm[0] = longint'($signed(data[17:0]));
      CFG_NORMAL_Y:  nrm[1] = longint'($signed(data[17:0]));
      CFG_NORMAL_Z:  nrm[2] = longint'($signed(data[17:0]));
      CFG_OFFSET:    offs = longint'($signed(data));
      CFG_THRESHOLD: thr = longint'(data[16:0]);
      default: ;
    endcase
  endfunction

  function longint fix_shift(longint x);
    return x >>> FRAC;
  endfunction

  function longint clip(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim - 1) return -lim - 1;
    return x;
  endfunction

  function longint dot_n(longint v[3]);
    return fix_shift(nrm[0] * v[0] + nrm[1] * v[1] + nrm[2] * v[2]);
  endfunction

  // Predict the result of one accepted query and queue it
  function void note_query(pgq_item_t it);
    pgq_res_t r;
    longint a[3], b[3], e, den, mag, nom, t, pt_dist, num;
    longint v[3], w[3], u[3];
    longint unsigned pden;
    int j, k;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(it.a[i]));
      b[i] = longint'($signed(it.b[i]));
    end
    e = longint'($signed(it.e));
    if (it.cmd == CMD_RAY) begin
      den = dot_n(b);
      mag = den < 0 ? -den : den;
      if (den != 0 && mag >= longint'(thr)) begin
        nom = dot_n(a) + offs;
        t = -((nom * 65536) / den);
        r.hit = t > 0;
        r.scalar = 32'(clip(t, 64'sh7FFF_FFFF));
      end
    end else if (it.cmd == CMD_POINT) begin
      pt_dist = dot_n(a) + offs;
      r.hit = 1'b1;
      r.scalar = 32'(clip(pt_dist, 64'sh7FFF_FFFF));
      r.side = pt_dist < 0 ? SIDE_BACK : (pt_dist > 0 ? SIDE_FRONT : SIDE_ON);
      for (int i = 0; i < 3; i++)
        r.out_a[i] = 32'(clip(a[i] - fix_shift(2 * nrm[i] * pt_dist), 64'sh7FFF_FFFF));
    end else if (it.cmd == CMD_PLANES) begin
      pden = 0;
      for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3; k = (i + 2) % 3;
        v[i] = clip(fix_shift(nrm[j] * a[k] - nrm[k] * a[j]), 64'sh7FFF_FFFF);
      end
      for (int i = 0; i < 3; i++) pden += longint'(v[i] * v[i]);
      pden = pden >> FRAC;
      if (pden > thr) begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3; k = (i + 2) % 3;
          w[i] = clip(fix_shift(v[j] * a[k]) - fix_shift(v[k] * a[j]), 64'sh7FFF_FFFF);
          u[i] = clip(fix_shift(nrm[j] * v[k] - nrm[k] * v[j]), 64'sh7FFF_FFFF);
        end
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
          num = clip(fix_shift(w[i] * offs) + fix_shift(u[i] * e), (64'sd1 <<< 47) - 1);
          r.out_a[i] = 32'(clip((num * 65536) / longint'(pden), 64'sh7FFF_FFFF));
          r.out_b[i] = 32'(v[i]);
        end
      end
    end
    results_due.push_back(r);
  endfunction

  function void check_result(pgq_res_t got);
    pgq_res_t want;
    if (results_due.size() == 0) begin
      $error("result with nothing outstanding");
      errors++;
      return;
    end
    want = results_due.pop_front();
    if (got.hit !== want.hit) begin
      $error("hit exp %0d got %0d", want.hit, got.hit); errors++;
    end
    if (got.scalar !== want.scalar) begin
      $error("scalar_value exp %h got %h", want.scalar, got.scalar); errors++;
    end
    if (got.side !== want.side) begin
      $error("side exp %0d got %0d", want.side, got.side); errors++;
    end
    for (int i = 0; i < 3; i++) begin
      if (got.out_a[i] !== want.out_a[i]) begin
        $error("out_a[%0d] exp %h got %h", i, want.out_a[i], got.out_a[i]); errors++;
      end
      if (got.out_b[i] !== want.out_b[i]) begin
        $error("out_b[%0d] exp %h got %h", i, want.out_b[i], got.out_b[i]); errors++;
      end
    end
  endfunction

  function int pending();
    return results_due.size();
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 80;
  localparam int ONE = 65536;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] command;
  logic [31:0] a_x, a_y, a_z, b_x, b_y, b_z, oth_d;
  logic out_valid, out_ready;
  logic hit;
  logic [31:0] scalar;
  logic [1:0] side;
  logic [31:0] oa_x, oa_y, oa_z, ob_x, ob_y, ob_z;

  plane_query_scoreboard sb;
  int cycles;
  int tx_max, rx_max;
  bit rx_hold_req;

  plane_geometry_query_unit_core u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command),
    .vec_a_x_i(a_x), .vec_a_y_i(a_y), .vec_a_z_i(a_z),
    .vec_b_x_i(b_x), .vec_b_y_i(b_y), .vec_b_z_i(b_z),
    .other_offset_i(oth_d),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .hit_o(hit), .scalar_value_o(scalar), .side_o(side),
    .out_a_x_o(oa_x), .out_a_y_o(oa_y), .out_a_z_o(oa_z),
    .out_b_x_o(ob_x), .out_b_y_o(ob_y), .out_b_z_o(ob_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Monitor both channels at the edge
  always @(posedge clk) begin
    pgq_item_t it;
    pgq_res_t r;
    if (rst_n && in_valid && in_ready) begin
      it.cmd = command;
      it.a[0] = a_x; it.a[1] = a_y; it.a[2] = a_z;
      it.b[0] = b_x; it.b[1] = b_y; it.b[2] = b_z;
      it.e = oth_d;
      sb.note_query(it);
    end
    if (rst_n && out_valid && out_ready) begin
      r.hit = hit; r.scalar = scalar; r.side = side;
      r.out_a[0] = oa_x; r.out_a[1] = oa_y; r.out_a[2] = oa_z;
      r.out_b[0] = ob_x; r.out_b[1] = ob_y; r.out_b[2] = ob_z;
      sb.check_result(r);
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (rx_hold_req) begin
        stall = 400;
        rx_hold_req = 0;
      end else begin
        stall = rx_max > 0 ? $urandom_range(0, rx_max) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_plane(int nx, int ny, int nz, logic [31:0] d, logic [16:0] t);
    // Junk in the upper bits of normal writes must be ignored
    write_reg(CFG_NORMAL_X, {14'($urandom_range(0, 16383)), 18'(nx)});
    write_reg(CFG_NORMAL_Y, {14'h0, 18'(ny)});
    write_reg(CFG_NORMAL_Z, {14'h3FFF, 18'(nz)});
    write_reg(CFG_OFFSET, d);
    write_reg(CFG_THRESHOLD, {15'h0, t});
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_query(logic [1:0] cmd, int ax, int ay, int az,
                            int bx, int by, int bz, int e);
    int gap;
    gap = tx_max > 0 ? $urandom_range(0, tx_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    oth_d <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return $urandom_range(0, 255) - 128;
      default: return int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
    endcase
  endfunction

  function automatic int rand_normal();
    return int'($urandom_range(0, 2 * ONE)) - ONE;
  endfunction

  task automatic random_queries(int count);
    int sel;
    logic [1:0] cmd;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      cmd = sel < 35 ? CMD_RAY : sel < 65 ? CMD_POINT : sel < 95 ? CMD_PLANES : CMD_NONE;
      if (cmd == CMD_PLANES && $urandom_range(0, 3) != 0)
        // Mostly unit-scale normals so the line point stays in range
        send_query(cmd, rand_normal(), rand_normal(), rand_normal(),
                   $urandom, $urandom, $urandom, rand_coord());
      else
        send_query(cmd, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), $urandom);
    end
    idle_input();
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; command = '0;
    a_x = '0; a_y = '0; a_z = '0; b_x = '0; b_y = '0; b_z = '0; oth_d = '0;
    tx_max = 4; rx_max = 4; rx_hold_req = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed queries against the reset plane z = 0
    send_query(CMD_RAY, 0, 0, 5 * ONE, 0, 0, -ONE, 0);        // hit at t = 5
    send_query(CMD_RAY, 0, 0, 5 * ONE, 0, 0, ONE, 0);         // behind origin
    send_query(CMD_RAY, 0, 0, 5 * ONE, ONE, 0, 0, 0);         // parallel ray
    send_query(CMD_RAY, ONE, ONE, ONE, 0, 0, 0, 0);           // zero direction
    send_query(CMD_RAY, 0, 0, 32'h7FFF_FFFF, 0, 0, -1, 0);    // t saturates
    send_query(CMD_RAY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_query(CMD_POINT, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0); // front
    send_query(CMD_POINT, ONE, 2 * ONE, -3 * ONE, 0, 0, 0, 0);// back
    send_query(CMD_POINT, ONE, 2 * ONE, 0, 0, 0, 0, 0);       // on plane
    send_query(CMD_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
    send_query(CMD_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
    send_query(CMD_PLANES, ONE, 0, 0, 0, 0, 0, 2 * ONE);      // planes meet
    send_query(CMD_PLANES, 0, 0, ONE, 0, 0, 0, 3 * ONE);      // parallel planes
    send_query(CMD_PLANES, 0, ONE, ONE, 0, 0, 0, 32'h8000_0000);
    send_query(CMD_PLANES, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               0, 0, 0, 32'h7FFF_FFFF);
    send_query(CMD_NONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
    idle_input();
    wait_drained();

    // Tilted plane, moderate threshold
    set_plane(39322, 52429, 0, 3 * ONE, 17'h100);
    send_query(CMD_RAY, 0, 0, 0, 39322, 52429, 0, 0);
    send_query(CMD_PLANES, 0, 0, ONE, 0, 0, 0, -ONE);
    send_query(CMD_POINT, 0, 0, 0, 0, 0, 0, 0);
    random_queries(70);
    wait_drained();

    // Extreme registers; hold the output long enough to fill the pipe
    set_plane(ONE, -ONE, ONE, 32'h7FFF_FFFF, 17'h0);
    tx_max = 0;
    rx_hold_req = 1;
    random_queries(80);
    wait_drained();

    // Other extremes with no idling on either side
    set_plane(-ONE, 0, -ONE, 32'h8000_0000, 17'h10000);
    rx_max = 0;
    random_queries(80);
    wait_drained();

    // Random plane, full idling, pause for a full drain midway
    tx_max = 16; rx_max = 16;
    set_plane(rand_normal(), rand_normal(), rand_normal(), rand_coord(),
              17'($urandom_range(0, ONE)));
    random_queries(40);
    while (sb.pending() != 0) @(posedge clk);
    random_queries(40);
    wait_drained();

    tx_max = 3; rx_max = 8;
    set_plane(rand_normal(), rand_normal(), rand_normal(), $urandom,
              17'($urandom_range(0, 64)));
    random_queries(80);
    wait_drained();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== plane_geometry_query_unit_core.f =====
hdl/pgq_pkg.sv
hdl/pgq_front.sv
hdl/pgq_div_lane.sv
hdl/pgq_back.sv
hdl/plane_geometry_query_unit_core.sv
hdl/pgq_checker.sv
tb/sv/testbench.sv
